>>> hdl/bba_pkg.sv
// Shared constants, codes and the result record of the buddy block allocator.
package bba_pkg;

  // Default geometry: 1 MiB arena, eight levels below the root
  localparam int ARENA_BYTES_DEF = 1048576;
  localparam int TREE_HEIGHT_DEF = 8;

  // Fixed field widths of the item ports
  localparam int FLD_OP_W     = 2;
  localparam int FLD_REQ_W    = 21;
  localparam int FLD_OFF_W    = 20;
  localparam int FLD_BYTES_W  = 21;
  localparam int FLD_STATUS_W = 2;

  // Operation codes; code three behaves as a query
  localparam logic [FLD_OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [FLD_OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [FLD_OP_W-1:0] OP_QUERY = 2'd2;

  // Status codes
  localparam logic [FLD_STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [FLD_STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [FLD_STATUS_W-1:0] ST_BADOFF  = 2'd2;

  // One finished result, handed from the sequencer to the output stage
  typedef struct packed {
    logic [FLD_STATUS_W-1:0] status;
    logic [FLD_OFF_W-1:0]    offset;
    logic [FLD_BYTES_W-1:0]  bytes;
    logic [FLD_BYTES_W-1:0]  total;
  } bba_res_t;

endpackage

>>> hdl/bba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module bba_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 511
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/bba_seq.sv
// Node sequencer: clearing pass, root query, depth-first allocate search, free walk, path update.
module bba_seq #(
  parameter int ARENA_BYTES = bba_pkg::ARENA_BYTES_DEF,
  parameter int TREE_HEIGHT = bba_pkg::TREE_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bba_pkg::FLD_OP_W-1:0]      in_operation,
  input  logic [bba_pkg::FLD_REQ_W-1:0]     in_request_size,
  input  logic [bba_pkg::FLD_OFF_W-1:0]     in_block_offset_in,
  // result towards the output stage
  output logic                              res_valid,
  input  logic                              res_ready,
  output bba_pkg::bba_res_t                 res,
  // node memory
  output logic                              wr_en,
  output logic [TREE_HEIGHT:0]              wr_addr,
  output logic [$clog2(ARENA_BYTES):0]      wr_data,
  output logic                              rd_en,
  output logic [TREE_HEIGHT:0]              rd_addr,
  input  logic [$clog2(ARENA_BYTES):0]      rd_data
);

  import bba_pkg::*;

  localparam int NODE_COUNT = (1 << (TREE_HEIGHT + 1)) - 1;
  localparam int IDX_W      = TREE_HEIGHT + 1;
  localparam int AW         = $clog2(ARENA_BYTES);
  localparam int SZ_W       = AW + 1;
  localparam logic [SZ_W-1:0]  ARENA_SZ = SZ_W'(ARENA_BYTES);
  localparam logic [SZ_W-1:0]  MIN_SZ   = ARENA_SZ >> TREE_HEIGHT;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);
  localparam logic [IDX_W-1:0] ROOT_IDX = '0;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_QUERY, S_ALLOC, S_BACK, S_FREE, S_UPD0, S_UPD, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        lvl_end_r, lvl_end_nxt;
  logic [SZ_W-1:0]         size_r, size_nxt;
  logic [AW-1:0]           base_r, base_nxt;
  logic [AW-1:0]           off_r, off_nxt;
  logic [SZ_W-1:0]         want_r, want_nxt;
  logic                    pend_r, pend_nxt;
  logic                    add_r, add_nxt;
  logic [SZ_W-1:0]         tot_r, tot_nxt;
  logic [FLD_STATUS_W-1:0] st_r, st_nxt;
  logic [AW-1:0]           roff_r, roff_nxt;
  logic [SZ_W-1:0]         rbytes_r, rbytes_nxt;

  // Request rounding and range checks on the incoming item
  logic [31:0]     req32;
  logic [31:0]     smear;
  logic [31:0]     want32;
  logic [SZ_W-1:0] want_calc;
  logic            too_big;
  logic            off_bad;

  always_comb begin
    req32 = 32'(in_request_size);
    smear = req32 - 32'd1;
    for (int k = 0; k < 5; k++) begin
      smear = smear | (smear >> (1 << k));
    end
    want32    = (req32 <= 32'(MIN_SZ)) ? 32'(MIN_SZ) : smear + 32'd1;
    want_calc = SZ_W'(want32);
    too_big   = req32 > 32'(ARENA_BYTES);
    off_bad   = 32'(in_block_offset_in) >= 32'(ARENA_BYTES);
  end

  // Tree navigation around the current node
  logic [SZ_W-1:0]  half;
  logic [IDX_W-1:0] left_idx;
  logic [IDX_W-1:0] right_idx;
  logic [IDX_W-1:0] parent_idx;
  logic [AW-1:0]    base_half;
  logic             at_base;
  logic [SZ_W-1:0]  upd_val;
  logic             do_back;

  assign half       = size_r >> 1;
  assign left_idx   = IDX_W'({idx_r, 1'b1});
  assign right_idx  = left_idx + IDX_W'(1);
  assign parent_idx = (idx_r - IDX_W'(1)) >> 1;
  assign base_half  = base_r + AW'(half);
  assign at_base    = off_r == base_r;
  assign upd_val    = add_r ? rd_data + rbytes_r : rd_data - rbytes_r;

  // Next-state logic
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    lvl_end_nxt = lvl_end_r;
    size_nxt    = size_r;
    base_nxt    = base_r;
    off_nxt     = off_r;
    want_nxt    = want_r;
    pend_nxt    = pend_r;
    add_nxt     = add_r;
    tot_nxt     = tot_r;
    st_nxt      = st_r;
    roff_nxt    = roff_r;
    rbytes_nxt  = rbytes_r;
    rd_en       = 1'b0;
    rd_addr     = idx_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = size_r;
    do_back     = 1'b0;

    unique case (state_r)
      // Write each node's full size, level by level
      S_CLEAR: begin
        wr_en = 1'b1;
        if (idx_r == lvl_end_r) begin
          size_nxt    = half;
          lvl_end_nxt = IDX_W'({lvl_end_r, 1'b0} + (IDX_W + 1)'(2));
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
          idx_nxt   = ROOT_IDX;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // Take an item and start reading the root
      S_IDLE: begin
        if (in_valid) begin
          rd_en      = 1'b1;
          rd_addr    = ROOT_IDX;
          idx_nxt    = ROOT_IDX;
          size_nxt   = ARENA_SZ;
          base_nxt   = '0;
          pend_nxt   = 1'b0;
          want_nxt   = want_calc;
          off_nxt    = AW'(32'(in_block_offset_in));
          st_nxt     = ST_OK;
          roff_nxt   = '0;
          rbytes_nxt = '0;
          unique case (in_operation)
            OP_ALLOC: begin
              if (too_big) begin
                st_nxt    = ST_NOSPACE;
                state_nxt = S_QUERY;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            OP_FREE: begin
              if (off_bad) begin
                st_nxt    = ST_BADOFF;
                state_nxt = S_QUERY;
              end else begin
                state_nxt = S_FREE;
              end
            end
            default: state_nxt = S_QUERY;
          endcase
        end
      end

      // Root value only
      S_QUERY: begin
        tot_nxt   = rd_data;
        state_nxt = S_DONE;
      end

      // Visit a node of the depth-first search
      S_ALLOC: begin
        if (idx_r == ROOT_IDX) begin
          tot_nxt = rd_data;
        end
        if (rd_data < want_r) begin
          do_back = 1'b1;
        end else if (size_r == want_r) begin
          roff_nxt   = base_r;
          rbytes_nxt = want_r;
          add_nxt    = 1'b0;
          state_nxt  = S_UPD0;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = left_idx;
          idx_nxt  = left_idx;
          size_nxt = half;
        end
      end

      // Parent has run out of children to try
      S_BACK: begin
        do_back = 1'b1;
      end

      // One node of the free walk; a zero node with a non-zero lower child is claimed
      S_FREE: begin
        if (idx_r == ROOT_IDX) begin
          tot_nxt = rd_data;
        end
        if (pend_r && rd_data != '0) begin
          idx_nxt    = parent_idx;
          rbytes_nxt = size_r << 1;
          add_nxt    = 1'b1;
          state_nxt  = S_UPD0;
        end else if (size_r == MIN_SZ) begin
          if (at_base && rd_data == '0) begin
            rbytes_nxt = size_r;
            add_nxt    = 1'b1;
            state_nxt  = S_UPD0;
          end else begin
            st_nxt    = ST_BADOFF;
            state_nxt = S_DONE;
          end
        end else begin
          pend_nxt = at_base && rd_data == '0;
          rd_en    = 1'b1;
          size_nxt = half;
          if (off_r >= base_half) begin
            rd_addr  = right_idx;
            idx_nxt  = right_idx;
            base_nxt = base_half;
          end else begin
            rd_addr = left_idx;
            idx_nxt = left_idx;
          end
        end
      end

      // Write the claimed or restored node, then fetch its parent unless it is the root
      S_UPD0: begin
        wr_en   = 1'b1;
        wr_data = add_r ? rbytes_r : '0;
        if (idx_r == ROOT_IDX) begin
          tot_nxt   = wr_data;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = parent_idx;
          idx_nxt   = parent_idx;
          state_nxt = S_UPD;
        end
      end

      // Ancestor read-modify-write, one level a cycle
      S_UPD: begin
        wr_en   = 1'b1;
        wr_data = upd_val;
        if (idx_r == ROOT_IDX) begin
          tot_nxt   = upd_val;
          state_nxt = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent_idx;
          idx_nxt = parent_idx;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Backtrack: try the upper sibling, else climb to the parent; at the root, report no space
    if (do_back) begin
      if (idx_r == ROOT_IDX) begin
        st_nxt     = ST_NOSPACE;
        roff_nxt   = '0;
        rbytes_nxt = '0;
        state_nxt  = S_DONE;
      end else if (idx_r[0]) begin
        rd_en     = 1'b1;
        rd_addr   = idx_r + IDX_W'(1);
        idx_nxt   = idx_r + IDX_W'(1);
        base_nxt  = base_r + AW'(size_r);
        state_nxt = S_ALLOC;
      end else begin
        idx_nxt   = parent_idx;
        size_nxt  = size_r << 1;
        base_nxt  = base_r - AW'(size_r);
        state_nxt = S_BACK;
      end
    end
  end

  // Control state, clearing-pass counters and working payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      idx_r     <= ROOT_IDX;
      size_r    <= ARENA_SZ;
      lvl_end_r <= ROOT_IDX;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      size_r    <= size_nxt;
      lvl_end_r <= lvl_end_nxt;
    end
    base_r   <= base_nxt;
    off_r    <= off_nxt;
    want_r   <= want_nxt;
    pend_r   <= pend_nxt;
    add_r    <= add_nxt;
    tot_r    <= tot_nxt;
    st_r     <= st_nxt;
    roff_r   <= roff_nxt;
    rbytes_r <= rbytes_nxt;
  end

  // Result record
  logic [31:0] roff32;
  logic [31:0] rbytes32;
  logic [31:0] tot32;

  assign roff32     = 32'(roff_r);
  assign rbytes32   = 32'(rbytes_r);
  assign tot32      = 32'(tot_r);
  assign in_ready   = state_r == S_IDLE;
  assign res_valid  = state_r == S_DONE;
  assign res.status = st_r;
  assign res.offset = roff32[FLD_OFF_W-1:0];
  assign res.bytes  = rbytes32[FLD_BYTES_W-1:0];
  assign res.total  = tot32[FLD_BYTES_W-1:0];

`ifndef ASSERT_OFF
  // Path updates never touch the node being fetched
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("node read and write collide");

  // A failed step reports no block
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != ST_OK |-> res.bytes == '0 && res.offset == '0)
    else $error("failed step carries a block");

  // Free space can never exceed the arena
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> tot_r <= ARENA_SZ)
    else $error("free total beyond arena");

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");
`endif

endmodule

>>> hdl/buddy_block_allocator.sv
// Top level of the buddy block allocator: node memory, sequencer and output register.
// The arena is split into a complete binary tree of power-of-two blocks, one RAM
// word per node holding the free bytes of its subtree. Each item is handled on its
// own and its time is set by the node RAM's single read port: one node per cycle.
// A query reads the root and returns its value as the free total. A free walks
// down by offset, up to TREE_HEIGHT+1 levels, and on success writes back the
// restored node and every ancestor. An allocate runs a depth-first search,
// stepping back over subtrees that are too full, then writes back the claimed
// node and every ancestor. After reset a clearing pass writes the full size of
// all 2^(TREE_HEIGHT+1)-1 nodes (511 by default), one node a cycle, with in_ready
// low. A finished result waits in the output register while the next item is
// accepted.
module buddy_block_allocator #(
  parameter int ARENA_BYTES = bba_pkg::ARENA_BYTES_DEF,
  parameter int TREE_HEIGHT = bba_pkg::TREE_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bba_pkg::FLD_OP_W-1:0]         in_operation,
  input  logic [bba_pkg::FLD_REQ_W-1:0]        in_request_size,
  input  logic [bba_pkg::FLD_OFF_W-1:0]        in_block_offset_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bba_pkg::FLD_STATUS_W-1:0]     out_status,
  output logic [bba_pkg::FLD_OFF_W-1:0]        out_block_offset_out,
  output logic [bba_pkg::FLD_BYTES_W-1:0]      out_block_bytes,
  output logic [bba_pkg::FLD_BYTES_W-1:0]      out_free_total
);

  import bba_pkg::*;

  localparam int NODE_COUNT = (1 << (TREE_HEIGHT + 1)) - 1;
  localparam int IDX_W      = TREE_HEIGHT + 1;
  localparam int SZ_W       = $clog2(ARENA_BYTES) + 1;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [SZ_W-1:0]  wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [SZ_W-1:0]  rd_data;
  logic             res_valid;
  logic             res_ready;
  bba_res_t         res;

  // Node memory
  bba_ram #(
    .WIDTH (SZ_W),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Search, walk and update sequencer
  bba_seq #(
    .ARENA_BYTES (ARENA_BYTES),
    .TREE_HEIGHT (TREE_HEIGHT)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_request_size    (in_request_size),
    .in_block_offset_in (in_block_offset_in),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .res                (res),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data)
  );

  // Output register: loads when empty or being drained
  logic     out_valid_r, out_valid_nxt;
  bba_res_t out_res_r;

  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = res_ready ? res_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_block_offset_out = out_res_r.offset;
  assign out_block_bytes      = out_res_r.bytes;
  assign out_free_total       = out_res_r.total;

endmodule

>>> sim/tb_buddy_block_allocator.sv
// Self-checking testbench for the buddy block allocator: tree predictor, directed and random items.
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  // Geometry of the default build
  localparam int unsigned ARENA     = ARENA_BYTES_DEF;
  localparam int unsigned HEIGHT    = TREE_HEIGHT_DEF;
  localparam int unsigned MIN_BLOCK = ARENA >> HEIGHT;
  localparam int unsigned NODES     = (2 ** (HEIGHT + 1)) - 1;

  // Spare operation code, handled as a query
  localparam logic [FLD_OP_W-1:0] OP_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_GAP      = 18;
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 100000;
  localparam int SETTLE       = 40;
  localparam int PRINT_LIMIT  = 50;

  // Free-space tree, expected results and the list of blocks currently held
  class tree_scoreboard;
    bit [FLD_BYTES_W-1:0] node_free [NODES];
    bba_res_t             expected_results [$];
    int unsigned          live_offsets [$];
    int errors, n_checked;
    int n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad, n_query;

    function new();
      for (int unsigned i = 0; i < NODES; i++) begin
        node_free[i] = FLD_BYTES_W'(ARENA >> ($clog2(i + 2) - 1));
      end
      errors = 0;
      n_checked = 0;
      n_alloc_ok = 0;
      n_alloc_fail = 0;
      n_free_ok = 0;
      n_free_bad = 0;
      n_query = 0;
    endfunction

    // Depth-first search, lower half first, for a wholly free node of the wanted size
    function bit claim_block(int unsigned idx, int unsigned depth, int unsigned size,
                             int unsigned base, int unsigned want, output int unsigned at);
      int unsigned half;
      int unsigned kid;
      half = size >> 1;
      at = 0;
      if (idx >= NODES || node_free[idx] < want) return 1'b0;
      if (size == want) begin
        node_free[idx] = '0;
        at = base;
        return 1'b1;
      end
      if (depth >= HEIGHT || size < want) return 1'b0;
      kid = 2 * idx + 1;
      if (kid < NODES && node_free[kid] >= want &&
          claim_block(kid, depth + 1, half, base, want, at)) begin
        node_free[idx] -= FLD_BYTES_W'(want);
        return 1'b1;
      end
      kid = 2 * idx + 2;
      if (kid < NODES && node_free[kid] >= want &&
          claim_block(kid, depth + 1, half, base + half, want, at)) begin
        node_free[idx] -= FLD_BYTES_W'(want);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Walk down by offset; give back the first claimed node starting there
    function int unsigned release_block(int unsigned off);
      int unsigned path [HEIGHT + 1];
      int unsigned n, idx, depth, size, base, half;
      bit leaf;
      n = 0;
      idx = 0;
      depth = 0;
      size = ARENA;
      base = 0;
      while (idx < NODES && n < HEIGHT + 1) begin
        leaf = (depth >= HEIGHT) || (2 * idx + 2 >= NODES);
        half = size >> 1;
        path[n] = idx;
        n++;
        if (off == base && node_free[idx] == 0 &&
            (leaf || (node_free[2 * idx + 1] != 0 && node_free[2 * idx + 2] != 0))) begin
          node_free[idx] = FLD_BYTES_W'(size);
          for (int unsigned i = 0; i + 1 < n; i++) node_free[path[i]] += FLD_BYTES_W'(size);
          return size;
        end
        if (leaf) return 0;
        if (off < base + half) begin
          idx = 2 * idx + 1;
        end else begin
          idx = 2 * idx + 2;
          base += half;
        end
        size = half;
        depth++;
      end
      return 0;
    endfunction

    // Accepted item: update the tree and queue the expected result
    function void note_request(logic [FLD_OP_W-1:0] op, logic [FLD_REQ_W-1:0] req,
                               logic [FLD_OFF_W-1:0] off);
      bba_res_t    exp_res;
      int unsigned blk, at;
      exp_res = '0;
      exp_res.status = ST_OK;
      if (op == OP_ALLOC) begin
        if (req > ARENA) begin
          exp_res.status = ST_NOSPACE;
        end else begin
          blk = MIN_BLOCK;
          while (blk < req) blk = blk << 1;
          if (claim_block(0, 0, ARENA, 0, blk, at)) begin
            exp_res.offset = FLD_OFF_W'(at);
            exp_res.bytes = FLD_BYTES_W'(blk);
            live_offsets.push_back(at);
          end else begin
            exp_res.status = ST_NOSPACE;
          end
        end
        if (exp_res.status == ST_OK) n_alloc_ok++;
        else n_alloc_fail++;
      end else if (op == OP_FREE) begin
        blk = (off >= ARENA) ? 0 : release_block(off);
        if (blk == 0) begin
          exp_res.status = ST_BADOFF;
          n_free_bad++;
        end else begin
          exp_res.bytes = FLD_BYTES_W'(blk);
          n_free_ok++;
          for (int i = 0; i < live_offsets.size(); i++) begin
            if (live_offsets[i] == off) begin
              live_offsets.delete(i);
              break;
            end
          end
        end
      end else begin
        n_query++;
      end
      exp_res.total = node_free[0];
      expected_results.push_back(exp_res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Accepted result against the oldest expectation, field by field
    task check_result(bba_res_t got);
      bba_res_t want;
      n_checked++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", n_checked));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("result %0d status %0d, expected %0d",
                           n_checked, got.status, want.status));
        if (got.offset !== want.offset)
          report($sformatf("result %0d offset 0x%05h, expected 0x%05h",
                           n_checked, got.offset, want.offset));
        if (got.bytes !== want.bytes)
          report($sformatf("result %0d bytes %0d, expected %0d",
                           n_checked, got.bytes, want.bytes));
        if (got.total !== want.total)
          report($sformatf("result %0d free total %0d, expected %0d",
                           n_checked, got.total, want.total));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [FLD_OP_W-1:0]     in_operation = OP_QUERY;
  logic [FLD_REQ_W-1:0]    in_request_size = '0;
  logic [FLD_OFF_W-1:0]    in_block_offset_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [FLD_STATUS_W-1:0] out_status;
  logic [FLD_OFF_W-1:0]    out_block_offset_out;
  logic [FLD_BYTES_W-1:0]  out_block_bytes;
  logic [FLD_BYTES_W-1:0]  out_free_total;

  tree_scoreboard sb = new();
  bit no_gaps = 1'b0;
  int n_sent = 0;
  int n_results = 0;

  buddy_block_allocator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_request_size      (in_request_size),
    .in_block_offset_in   (in_block_offset_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_block_offset_out (out_block_offset_out),
    .out_block_bytes      (out_block_bytes),
    .out_free_total       (out_free_total)
  );

  always #10 clk = ~clk;

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [FLD_OP_W-1:0] op, input logic [FLD_REQ_W-1:0] req,
                           input logic [FLD_OFF_W-1:0] off);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_request_size    <= req;
    in_block_offset_in <= off;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(op, req, off);
    n_sent++;
  endtask

  // Request sizes: mostly small blocks, some large, a few zero, a few random that may exceed the arena
  function automatic logic [FLD_REQ_W-1:0] pick_size();
    int roll, sh;
    roll = $urandom_range(0, 99);
    if (roll < 5) return FLD_REQ_W'($urandom);
    if (roll < 8) return '0;
    sh = (roll < 80) ? $urandom_range(12, 15) : $urandom_range(16, 20);
    return FLD_REQ_W'($urandom_range(1 << (sh - 1), 1 << sh));
  endfunction

  // One random item; phases alternate between filling and draining the arena
  task automatic send_random(input int n);
    int roll, alloc_pct;
    logic [FLD_OFF_W-1:0] off;
    roll = $urandom_range(0, 99);
    alloc_pct = ((n / 250) % 2 == 0) ? 55 : 30;
    off = FLD_OFF_W'($urandom);
    if (roll < alloc_pct) begin
      send_item(OP_ALLOC, pick_size(), off);
    end else if (roll < 85 && sb.live_offsets.size() > 0) begin
      off = FLD_OFF_W'(sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)]);
      send_item(OP_FREE, FLD_REQ_W'($urandom), off);
    end else if (roll < 92) begin
      // stray offsets, half of them on a minimum-block boundary
      if ($urandom_range(0, 1)) off = off & ~(FLD_OFF_W'(MIN_BLOCK - 1));
      send_item(OP_FREE, FLD_REQ_W'($urandom), off);
    end else if (roll < 97) begin
      send_item(OP_QUERY, FLD_REQ_W'($urandom), off);
    end else begin
      send_item(OP_SPARE, FLD_REQ_W'($urandom), off);
    end
  endtask

  // Receiver: random stalls, one long hold-off so the block backs up
  initial begin : receiver
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (n_results == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result('{out_status, out_block_offset_out, out_block_bytes, out_free_total});
      n_results++;
    end
  end

  // Main sequence
  initial begin : stimulus
    int idle;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tree, whole arena, oversize, small blocks, bad and double frees
    send_item(OP_QUERY,  '0,          '0);
    send_item(OP_SPARE,  '1,          '1);
    send_item(OP_FREE,   '0,          '0);
    send_item(OP_ALLOC,  21'd1048576, '0);
    send_item(OP_ALLOC,  '0,          '0);
    send_item(OP_QUERY,  '0,          '0);
    send_item(OP_FREE,   '0,          20'd4096);
    send_item(OP_FREE,   '0,          '0);
    send_item(OP_ALLOC,  '1,          '0);
    send_item(OP_ALLOC,  21'd1048577, '0);
    send_item(OP_ALLOC,  '0,          '0);
    send_item(OP_ALLOC,  21'd1,       '0);
    send_item(OP_ALLOC,  21'd4097,    '0);
    send_item(OP_ALLOC,  21'd524288,  '0);
    send_item(OP_ALLOC,  21'd524289,  '0);
    send_item(OP_FREE,   '1,          '1);
    send_item(OP_FREE,   '0,          20'd4096);
    send_item(OP_FREE,   '0,          20'd4096);
    send_item(OP_FREE,   '0,          20'd8192);
    send_item(OP_FREE,   '0,          '0);
    send_item(OP_FREE,   '0,          20'd524288);
    send_item(OP_ALLOC,  21'd4096,    '1);
    send_item(OP_FREE,   '0,          '0);
    send_item(OP_QUERY,  '1,          '1);

    // Random traffic with two stretches of back-to-back items
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_gaps = (i >= 300 && i < 500) || (i >= 1300 && i < 1450);
      send_random(i);
    end
    no_gaps = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for any stray output
    idle = 0;
    while (sb.expected_results.size() != 0 && idle < DRAIN_LIMIT) begin
      @(posedge clk);
      idle++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.expected_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));

    $display("Sent %0d items, checked %0d results; receiver held off %0d cycles once.",
             n_sent, sb.n_checked, HOLD_CYCLES);
    $display("Allocations %0d ok / %0d refused, frees %0d ok / %0d rejected, queries %0d.",
             sb.n_alloc_ok, sb.n_alloc_fail, sb.n_free_ok, sb.n_free_bad, sb.n_query);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(150_000_000);
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
